// ===== design/rgbhsl_pkg.sv =====
// shared types and constants for the rgb to hsl converter
package rgbhsl_pkg;

  // fraction bits of hue and saturation, one division cell per bit
  localparam int FRAC_BITS = 16;

  // extra bits that the hue divisor 6*d needs above a channel
  localparam int HUE_EXTRA_BITS = 3;

  typedef struct packed {
    logic grey;   // max equals min
    logic full;   // saturation quotient reaches one, clamp to all ones
  } flags_t;

endpackage

// ===== design/rgbhsl_prep.sv =====
// front stage: extrema, lightness and the two division operands
module rgbhsl_prep #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  logic [CHANNEL_BITS-1:0]                                 in_red,
  input  logic [CHANNEL_BITS-1:0]                                 in_green,
  input  logic [CHANNEL_BITS-1:0]                                 in_blue,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output rgbhsl_pkg::flags_t                                      out_flags,
  output logic [CHANNEL_BITS:0]                                   out_light,
  output logic [CHANNEL_BITS-1:0]                                 out_div_s,
  output logic [CHANNEL_BITS-1:0]                                 out_rem_s,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_EXTRA_BITS-1:0]      out_div_h,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_EXTRA_BITS-1:0]      out_rem_h
);

  localparam int HW = CHANNEL_BITS + rgbhsl_pkg::HUE_EXTRA_BITS;

  logic [CHANNEL_BITS-1:0] mx, mn, d, div_s;
  logic [CHANNEL_BITS:0]   sum, two_m;
  logic [HW-1:0]           d_w, six_d, num;
  logic                    red_max, green_max;
  rgbhsl_pkg::flags_t      flags;

  logic                         valid_r, valid_nxt;
  rgbhsl_pkg::flags_t           flags_r;
  logic [CHANNEL_BITS:0]        light_r;
  logic [CHANNEL_BITS-1:0]      div_s_r, rem_s_r;
  logic [HW-1:0]                div_h_r, rem_h_r;

  always_comb begin
    red_max   = (in_red >= in_green) && (in_red >= in_blue);
    green_max = !red_max && (in_green >= in_blue);
    if (red_max) begin
      mx = in_red;
    end else if (green_max) begin
      mx = in_green;
    end else begin
      mx = in_blue;
    end
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;

    sum   = {1'b0, mx} + {1'b0, mn};
    d     = mx - mn;
    two_m = {{CHANNEL_BITS{1'b1}}, 1'b0};
    if (sum <= {1'b0, {CHANNEL_BITS{1'b1}}}) begin
      div_s = sum[CHANNEL_BITS-1:0];
    end else begin
      div_s = CHANNEL_BITS'(two_m - sum);
    end

    d_w   = HW'(d);
    six_d = (d_w << 2) + (d_w << 1);
    // modular arithmetic: every sector ends non-negative and below 6*d
    if (red_max) begin
      num = ((in_green < in_blue) ? six_d : '0) + HW'(in_green) - HW'(in_blue);
    end else if (green_max) begin
      num = (d_w << 1) + HW'(in_blue) - HW'(in_red);
    end else begin
      num = (d_w << 2) + HW'(in_red) - HW'(in_green);
    end

    flags.grey = (d == '0);
    flags.full = (d == div_s);
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      flags_r <= flags;
      light_r <= sum;
      div_s_r <= div_s;
      rem_s_r <= flags.full ? '0 : d;
      div_h_r <= six_d;
      rem_h_r <= num;
    end
  end

  assign out_valid = valid_r;
  assign out_flags = flags_r;
  assign out_light = light_r;
  assign out_div_s = div_s_r;
  assign out_rem_s = rem_s_r;
  assign out_div_h = div_h_r;
  assign out_rem_h = rem_h_r;

endmodule

// ===== design/rgbhsl_div_cell.sv =====
// one restoring division step for saturation and hue, one quotient bit each
module rgbhsl_div_cell #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    in_valid,
  output logic                                                    in_ready,
  input  rgbhsl_pkg::flags_t                                      in_flags,
  input  logic [CHANNEL_BITS:0]                                   in_light,
  input  logic [CHANNEL_BITS-1:0]                                 in_div_s,
  input  logic [CHANNEL_BITS-1:0]                                 in_rem_s,
  input  logic [rgbhsl_pkg::FRAC_BITS-1:0]                        in_q_s,
  input  logic [CHANNEL_BITS+rgbhsl_pkg::HUE_EXTRA_BITS-1:0]      in_div_h,
  input  logic [CHANNEL_BITS+rgbhsl_pkg::HUE_EXTRA_BITS-1:0]      in_rem_h,
  input  logic [rgbhsl_pkg::FRAC_BITS-1:0]                        in_q_h,
  output logic                                                    out_valid,
  input  logic                                                    out_ready,
  output rgbhsl_pkg::flags_t                                      out_flags,
  output logic [CHANNEL_BITS:0]                                   out_light,
  output logic [CHANNEL_BITS-1:0]                                 out_div_s,
  output logic [CHANNEL_BITS-1:0]                                 out_rem_s,
  output logic [rgbhsl_pkg::FRAC_BITS-1:0]                        out_q_s,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_EXTRA_BITS-1:0]      out_div_h,
  output logic [CHANNEL_BITS+rgbhsl_pkg::HUE_EXTRA_BITS-1:0]      out_rem_h,
  output logic [rgbhsl_pkg::FRAC_BITS-1:0]                        out_q_h
);

  localparam int HW = CHANNEL_BITS + rgbhsl_pkg::HUE_EXTRA_BITS;
  localparam int FB = rgbhsl_pkg::FRAC_BITS;

  logic [CHANNEL_BITS:0]   two_s, diff_s;
  logic [HW:0]             two_h, diff_h;
  logic                    bit_s, bit_h;
  logic [CHANNEL_BITS-1:0] rem_s_nxt;
  logic [HW-1:0]           rem_h_nxt;

  logic                    valid_r, valid_nxt;
  rgbhsl_pkg::flags_t      flags_r;
  logic [CHANNEL_BITS:0]   light_r;
  logic [CHANNEL_BITS-1:0] div_s_r, rem_s_r;
  logic [FB-1:0]           q_s_r, q_h_r;
  logic [HW-1:0]           div_h_r, rem_h_r;

  // remainder stays below the divisor, so one compare and subtract per bit
  always_comb begin
    two_s     = {in_rem_s, 1'b0};
    diff_s    = two_s - {1'b0, in_div_s};
    bit_s     = (two_s >= {1'b0, in_div_s});
    rem_s_nxt = bit_s ? diff_s[CHANNEL_BITS-1:0] : two_s[CHANNEL_BITS-1:0];
    two_h     = {in_rem_h, 1'b0};
    diff_h    = two_h - {1'b0, in_div_h};
    bit_h     = (two_h >= {1'b0, in_div_h});
    rem_h_nxt = bit_h ? diff_h[HW-1:0] : two_h[HW-1:0];
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      flags_r <= in_flags;
      light_r <= in_light;
      div_s_r <= in_div_s;
      rem_s_r <= rem_s_nxt;
      q_s_r   <= {in_q_s[FB-2:0], bit_s};
      div_h_r <= in_div_h;
      rem_h_r <= rem_h_nxt;
      q_h_r   <= {in_q_h[FB-2:0], bit_h};
    end
  end

  assign out_valid = valid_r;
  assign out_flags = flags_r;
  assign out_light = light_r;
  assign out_div_s = div_s_r;
  assign out_rem_s = rem_s_r;
  assign out_q_s   = q_s_r;
  assign out_div_h = div_h_r;
  assign out_rem_h = rem_h_r;
  assign out_q_h   = q_h_r;

endmodule

// ===== design/rgb_to_hsl_converter.sv =====
// rgb to hsl converter top level: front stage, division cell row, output register
//
//   channel  ports                                   dir  request moves when
//   in       in_valid in_stall in_red/green/blue     in   in_valid && !in_stall
//   out      out_valid out_stall out_hue/            out  out_valid && !out_stall
//            out_saturation/out_lightness
//
// one pixel per clock sustained while out_stall is low; the path runs through the front stage,
// 16 division cells (one quotient bit per cell for hue and saturation),
// and the output register.
// every stage holds its request while the next one is full and stalled, so
// bubbles close up; rst_n clears the valid bits only.
module rgb_to_hsl_converter #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [CHANNEL_BITS-1:0]           in_red,
  input  logic [CHANNEL_BITS-1:0]           in_green,
  input  logic [CHANNEL_BITS-1:0]           in_blue,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rgbhsl_pkg::FRAC_BITS-1:0]  out_hue,
  output logic [rgbhsl_pkg::FRAC_BITS-1:0]  out_saturation,
  output logic [CHANNEL_BITS:0]             out_lightness
);

  localparam int HW = CHANNEL_BITS + rgbhsl_pkg::HUE_EXTRA_BITS;
  localparam int FB = rgbhsl_pkg::FRAC_BITS;

  logic                    vld   [FB+1];
  logic                    rdy   [FB+1];
  rgbhsl_pkg::flags_t      flg   [FB+1];
  logic [CHANNEL_BITS:0]   light [FB+1];
  logic [CHANNEL_BITS-1:0] div_s [FB+1];
  logic [CHANNEL_BITS-1:0] rem_s [FB+1];
  logic [FB-1:0]           q_s   [FB+1];
  logic [HW-1:0]           div_h [FB+1];
  logic [HW-1:0]           rem_h [FB+1];
  logic [FB-1:0]           q_h   [FB+1];

  logic                    prep_ready;
  logic                    out_ready;
  logic                    out_valid_r, out_valid_nxt;
  logic [FB-1:0]           hue_r, sat_r;
  logic [CHANNEL_BITS:0]   light_r;

  rgbhsl_prep #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (prep_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_flags (flg[0]),
    .out_light (light[0]),
    .out_div_s (div_s[0]),
    .out_rem_s (rem_s[0]),
    .out_div_h (div_h[0]),
    .out_rem_h (rem_h[0])
  );

  assign q_s[0]   = '0;
  assign q_h[0]   = '0;
  assign in_stall = !prep_ready;

  for (genvar i = 0; i < FB; i++) begin : g_cell
    rgbhsl_div_cell #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i]),
      .in_flags  (flg[i]),
      .in_light  (light[i]),
      .in_div_s  (div_s[i]),
      .in_rem_s  (rem_s[i]),
      .in_q_s    (q_s[i]),
      .in_div_h  (div_h[i]),
      .in_rem_h  (rem_h[i]),
      .in_q_h    (q_h[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+1]),
      .out_flags (flg[i+1]),
      .out_light (light[i+1]),
      .out_div_s (div_s[i+1]),
      .out_rem_s (rem_s[i+1]),
      .out_q_s   (q_s[i+1]),
      .out_div_h (div_h[i+1]),
      .out_rem_h (rem_h[i+1]),
      .out_q_h   (q_h[i+1])
    );
  end

  assign out_ready     = !out_valid_r || !out_stall;
  assign rdy[FB]       = out_ready;
  assign out_valid_nxt = out_ready ? vld[FB] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // grey pixels give zero hue and saturation; a full saturation quotient clamps to all ones
  always_ff @(posedge clk) begin
    if (out_ready && vld[FB]) begin
      light_r <= light[FB];
      if (flg[FB].grey) begin
        hue_r <= '0;
        sat_r <= '0;
      end else begin
        hue_r <= q_h[FB];
        sat_r <= flg[FB].full ? '1 : q_s[FB];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_lightness  = light_r;

endmodule
